// ===== hw/rtl/btd_pkg.sv =====
package btd_pkg;

    // Byte class masks and patterns
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;

    // Code point landmarks
    localparam logic [15:0] CP_WORD_MARK  = 16'h2581;
    localparam logic [15:0] CP_PASS_ABOVE = 16'h2580;
    localparam logic [15:0] CP_SHIFT_BASE = 16'd256;
    localparam logic [15:0] IDX_LOW_LAST  = 16'd32;
    localparam logic [15:0] IDX_MID_LAST  = 16'd66;
    localparam logic [7:0]  IDX_MID_OFS   = 8'd94;   // 127 - 33
    localparam logic [7:0]  SOFT_HYPHEN   = 8'd173;
    localparam logic [7:0]  SPACE_BYTE    = 8'h20;

    // Held sequence depth
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_LEAD = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    // Results released by one request
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
        logic            fin;
    } result_t;

    // Decoded code point: pass means emit the original bytes
    typedef struct packed {
        logic       pass;
        logic [7:0] value;
    } map_t;

    function automatic map_t map_cp(input logic [15:0] cp);
        map_t       m;
        logic [15:0] idx;
        idx     = cp - CP_SHIFT_BASE;
        m.pass  = 1'b0;
        m.value = cp[7:0];
        if (cp == CP_WORD_MARK) begin
            m.value = SPACE_BYTE;
        end else if (cp > CP_PASS_ABOVE) begin
            m.pass = 1'b1;
        end else if ((cp >= 16'd33 && cp <= 16'd126) ||
                     (cp >= 16'd161 && cp <= 16'd172) ||
                     (cp >= 16'd174 && cp <= 16'd255)) begin
            m.value = cp[7:0];
        end else if (cp >= CP_SHIFT_BASE) begin
            if (idx <= IDX_LOW_LAST) begin
                m.value = idx[7:0];
            end else if (idx <= IDX_MID_LAST) begin
                m.value = idx[7:0] + IDX_MID_OFS;
            end else begin
                m.value = SOFT_HYPHEN;
            end
        end else begin
            m.pass = 1'b1;
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/byte_level_token_text_decoder_unit.sv =====
// Channel   Ports                                         Carries
// s_        s_valid s_ready s_in_byte s_is_final           one token byte
// m_        m_valid m_ready m_out_byte m_run_end m_string_end  one text byte
//
// A byte is taken each cycle while m_ready is high and results drain at one
// per cycle; a request releasing two or three bytes holds s_ready low until its last byte leaves.
// Non-final leads wait in the decoder, releasing nothing until completed or cut short.
// aresetn (synchronous, active low) clears the held count and the result buffer.
// A stall on m_ accepts one more request only as the last buffered byte leaves.
module byte_level_token_text_decoder_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_is_final,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_end,
    output logic       m_string_end
);

    btd_pkg::result_t res;
    logic             accept;

    assign accept = s_valid && s_ready;

    btd_decode u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .in_byte  (s_in_byte),
        .is_final (s_is_final),
        .res      (res)
    );

    btd_outq u_outq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (accept),
        .res          (res),
        .can_push     (s_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_run_end    (m_run_end),
        .m_string_end (m_string_end)
    );

endmodule

// ===== hw/rtl/btd_decode.sv =====
module btd_decode (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    input  logic              is_final,
    output btd_pkg::result_t  res
);

    logic [1:0] held_count_reg, held_count_next;
    logic       wants_three_reg, wants_three_next;
    logic [7:0] held0_reg, held0_next;
    logic [7:0] held1_reg, held1_next;

    logic        lead2, lead3;
    logic [15:0] cp2, cp3;
    btd_pkg::map_t m2, m3;

    // Code points of the two sequence lengths
    assign lead2 = (in_byte & btd_pkg::LEAD2_MASK) == btd_pkg::LEAD2_PAT;
    assign lead3 = (in_byte & btd_pkg::LEAD3_MASK) == btd_pkg::LEAD3_PAT;
    assign cp2   = {5'd0, held0_reg[4:0], in_byte[5:0]};
    assign cp3   = {held0_reg[3:0], held1_reg[5:0], in_byte[5:0]};
    assign m2    = btd_pkg::map_cp(cp2);
    assign m3    = btd_pkg::map_cp(cp3);

    // Result and next held state for the incoming byte
    always_comb begin
        res              = '0;
        res.fin          = is_final;
        held_count_next  = held_count_reg;
        wants_three_next = wants_three_reg;
        held0_next       = held0_reg;
        held1_next       = held1_reg;
        if (held_count_reg == btd_pkg::HELD_LEAD && !wants_three_reg) begin
            held_count_next = btd_pkg::HELD_NONE;
            if (m2.pass) begin
                res.count = 2'd2;
                res.bytes = {8'd0, in_byte, held0_reg};
            end else begin
                res.count = 2'd1;
                res.bytes = {16'd0, m2.value};
            end
        end else if (held_count_reg == btd_pkg::HELD_LEAD) begin
            if (is_final) begin
                // three-byte lead cut short: both go out raw
                held_count_next = btd_pkg::HELD_NONE;
                res.count       = 2'd2;
                res.bytes       = {8'd0, in_byte, held0_reg};
            end else begin
                held1_next      = in_byte;
                held_count_next = btd_pkg::HELD_TWO;
            end
        end else if (held_count_reg == btd_pkg::HELD_TWO) begin
            held_count_next = btd_pkg::HELD_NONE;
            if (m3.pass) begin
                res.count = 2'd3;
                res.bytes = {in_byte, held1_reg, held0_reg};
            end else begin
                res.count = 2'd1;
                res.bytes = {16'd0, m3.value};
            end
        end else begin
            held_count_next = btd_pkg::HELD_NONE;
            if ((lead2 || lead3) && !is_final) begin
                held0_next       = in_byte;
                wants_three_next = lead3;
                held_count_next  = btd_pkg::HELD_LEAD;
            end else begin
                res.count = 2'd1;
                res.bytes = {16'd0, in_byte};
            end
        end
    end

    // Held state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg  <= btd_pkg::HELD_NONE;
            wants_three_reg <= 1'b0;
        end else if (accept) begin
            held_count_reg  <= held_count_next;
            wants_three_reg <= wants_three_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

endmodule

// ===== hw/rtl/btd_outq.sv =====
module btd_outq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  btd_pkg::result_t  res,
    output logic              can_push,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic              m_run_end,
    output logic              m_string_end
);

    logic [1:0]      cnt_reg, cnt_next;
    logic [1:0]      idx_reg, idx_next;
    logic [2:0][7:0] bytes_reg;
    logic            fin_reg;
    logic            last;
    logic            pop;

    assign m_valid      = cnt_reg != 2'd0;
    assign last         = idx_reg == (cnt_reg - 2'd1);
    assign pop          = m_valid && m_ready;
    assign can_push     = !m_valid || (pop && last);
    assign m_run_end    = last;
    assign m_string_end = last && fin_reg;

    // Pick the byte at the read position
    always_comb begin
        case (idx_reg)
            2'd0:    m_out_byte = bytes_reg[0];
            2'd1:    m_out_byte = bytes_reg[1];
            2'd2:    m_out_byte = bytes_reg[2];
            default: m_out_byte = bytes_reg[0];
        endcase
    end

    // Drain one byte per taken request, reload from the decoder
    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (pop) begin
            if (last) begin
                cnt_next = 2'd0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
        if (push && res.count != 2'd0) begin
            cnt_next = res.count;
            idx_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && res.count != 2'd0) begin
            bytes_reg <= res.bytes;
            fin_reg   <= res.fin;
        end
    end

endmodule

// ===== hw/rtl/btd_checker.sv =====
module btd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_in_byte,
    input logic       s_is_final,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_run_end,
    input logic       m_string_end
);

    // A stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) &&
        $stable(m_run_end) && $stable(m_string_end))
        else $error("stalled result changed");

    // End of string is always end of run
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_string_end |-> m_run_end)
        else $error("string end without run end");

    // Nothing pending right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Pending bytes of a run block new requests
    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (!m_ready || !m_run_end) |-> !s_ready)
        else $error("request taken with results pending");

    // Empty buffer always takes a request
    a_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("idle block not ready");

endmodule

bind byte_level_token_text_decoder_unit btd_checker u_btd_checker (.*);
